// ----- src/ufpc_pkg.sv -----
// shared types, constants and microprogram of the union-find table
package ufpc_pkg;

    localparam int NODES   = 1024;
    localparam int ADDR_W  = $clog2(NODES);
    localparam int IDX_W   = 10;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 16;

    localparam logic KIND_FIND  = 1'b0;
    localparam logic KIND_MERGE = 1'b1;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [IDX_W-1:0]  idx_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_WAIT,
        S_SETUP,
        S_WALK,
        S_CREAD,
        S_CWRITE,
        S_FDONE,
        S_LINK
    } step_t;

    typedef enum logic [2:0] {
        OP_CLEAR,
        OP_ACCEPT,
        OP_SETUP,
        OP_WALK,
        OP_CREAD,
        OP_CWRITE,
        OP_FDONE,
        OP_LINK
    } op_t;

    typedef enum logic [2:0] {
        COND_ACCEPT,
        COND_DIFF,
        COND_CUR_ROOT,
        COND_MERGE_FIRST,
        COND_OUT_BUSY,
        COND_CLR_LAST
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t t_true;
        step_t t_false;
    } ctl_word_t;

    function automatic ctl_word_t ucode(input step_t pc);
        ctl_word_t w;
        unique case (pc)
            S_CLEAR:  w = '{op: OP_CLEAR,  cond: COND_CLR_LAST,    t_true: S_WAIT,   t_false: S_CLEAR};
            S_WAIT:   w = '{op: OP_ACCEPT, cond: COND_ACCEPT,      t_true: S_SETUP,  t_false: S_WAIT};
            S_SETUP:  w = '{op: OP_SETUP,  cond: COND_DIFF,        t_true: S_WALK,   t_false: S_WALK};
            S_WALK:   w = '{op: OP_WALK,   cond: COND_DIFF,        t_true: S_WALK,   t_false: S_CREAD};
            S_CREAD:  w = '{op: OP_CREAD,  cond: COND_CUR_ROOT,    t_true: S_FDONE,  t_false: S_CWRITE};
            S_CWRITE: w = '{op: OP_CWRITE, cond: COND_DIFF,        t_true: S_CWRITE, t_false: S_FDONE};
            S_FDONE:  w = '{op: OP_FDONE,  cond: COND_MERGE_FIRST, t_true: S_SETUP,  t_false: S_LINK};
            S_LINK:   w = '{op: OP_LINK,   cond: COND_OUT_BUSY,    t_true: S_LINK,   t_false: S_WAIT};
            default:  w = '{op: OP_CLEAR,  cond: COND_CLR_LAST,    t_true: S_WAIT,   t_false: S_CLEAR};
        endcase
        return w;
    endfunction

    function automatic addr_t clamp_node(input idx_t v);
        if (32'(v) >= NODES) begin
            return ADDR_W'(NODES - 1);
        end
        return ADDR_W'(v);
    endfunction

endpackage

// ----- src/ufpc_ram.sv -----
// generic simple dual-port ram with registered read
module ufpc_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- src/union_find_path_compression.sv -----
// union-find table with path compression, microcoded over one parent-link ram
// A find transaction walks the parent chain of node_a one ram read per cycle, then
// rewrites each node on the path to point at the root, one node per cycle. A merge
// adds a second find for node_b, and the link of the two roots is written in the
// same cycle that loads the result; the sequence then returns to the waiting step
// that accepts the next transaction. Every walk and rewrite step goes through the
// single registered read port of the link ram. After reset a clearing pass writes
// each entry to point at itself, during which s_tready stays low. Node indexes of
// NODES or more are clamped to NODES-1. A finished result waits in the output
// register while the next transaction is accepted.
module union_find_path_compression (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ufpc_pkg::S_DATA_W-1:0] s_tdata,  // node_a [9:0], node_b [19:10], zero [23:20]
    input  logic                          s_tuser,  // kind
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ufpc_pkg::M_DATA_W-1:0] m_tdata   // root [9:0], joined [10], zero [15:11]
);

    ufpc_pkg::step_t     pc_reg, pc_next;
    ufpc_pkg::ctl_word_t ctl;
    logic                take;

    ufpc_pkg::addr_t a_reg, a_next;
    ufpc_pkg::addr_t b_reg, b_next;
    logic            kind_reg, kind_next;
    ufpc_pkg::addr_t start_reg, start_next;
    ufpc_pkg::addr_t r_reg, r_next;
    ufpc_pkg::addr_t cur_reg, cur_next;
    ufpc_pkg::addr_t ra_reg, ra_next;
    logic            sel_reg, sel_next;
    ufpc_pkg::addr_t clr_reg, clr_next;
    logic            m_valid_reg, m_valid_next;
    ufpc_pkg::idx_t  m_root_reg, m_root_next;
    logic            m_joined_reg, m_joined_next;

    logic            wr_en;
    ufpc_pkg::addr_t wr_addr, wr_data, rd_addr, rd_data;
    logic            out_busy;
    logic            link_fire;

    assign ctl       = ufpc_pkg::ucode(pc_reg);
    assign out_busy  = m_valid_reg && !m_tready;
    assign link_fire = (ctl.op == ufpc_pkg::OP_LINK) && !out_busy;

    assign s_tready = (pc_reg == ufpc_pkg::S_WAIT);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(ufpc_pkg::M_DATA_W - ufpc_pkg::IDX_W - 1)'(0), m_joined_reg, m_root_reg};

    ufpc_ram #(
        .WIDTH (ufpc_pkg::ADDR_W),
        .DEPTH (ufpc_pkg::NODES)
    ) u_link_ram (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= ufpc_pkg::S_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
            sel_reg     <= 1'b0;
        end else begin
            pc_reg      <= pc_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
            sel_reg     <= sel_next;
        end
        a_reg        <= a_next;
        b_reg        <= b_next;
        kind_reg     <= kind_next;
        start_reg    <= start_next;
        r_reg        <= r_next;
        cur_reg      <= cur_next;
        ra_reg       <= ra_next;
        m_root_reg   <= m_root_next;
        m_joined_reg <= m_joined_next;
    end

    // condition select and step sequencing
    always_comb begin
        unique case (ctl.cond)
            ufpc_pkg::COND_ACCEPT:      take = s_tvalid;
            ufpc_pkg::COND_DIFF:        take = (rd_data != r_reg);
            ufpc_pkg::COND_CUR_ROOT:    take = (cur_reg == r_reg);
            ufpc_pkg::COND_MERGE_FIRST: take = (kind_reg == ufpc_pkg::KIND_MERGE) && !sel_reg;
            ufpc_pkg::COND_OUT_BUSY:    take = out_busy;
            ufpc_pkg::COND_CLR_LAST:    take = (clr_reg == ufpc_pkg::ADDR_W'(ufpc_pkg::NODES - 1));
            default:                    take = 1'b0;
        endcase
        pc_next = take ? ctl.t_true : ctl.t_false;
    end

    // datapath driven by the control word
    always_comb begin
        a_next        = a_reg;
        b_next        = b_reg;
        kind_next     = kind_reg;
        start_next    = start_reg;
        r_next        = r_reg;
        cur_next      = cur_reg;
        ra_next       = ra_reg;
        sel_next      = sel_reg;
        clr_next      = clr_reg;
        m_root_next   = m_root_reg;
        m_joined_next = m_joined_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        wr_en         = 1'b0;
        wr_addr       = clr_reg;
        wr_data       = clr_reg;
        rd_addr       = r_reg;

        unique case (ctl.op)
            ufpc_pkg::OP_CLEAR: begin
                wr_en    = 1'b1;
                clr_next = clr_reg + ufpc_pkg::addr_t'(1);
            end
            ufpc_pkg::OP_ACCEPT: begin
                if (s_tvalid) begin
                    a_next     = ufpc_pkg::clamp_node(s_tdata[9:0]);
                    b_next     = ufpc_pkg::clamp_node(s_tdata[19:10]);
                    kind_next  = s_tuser;
                    start_next = ufpc_pkg::clamp_node(s_tdata[9:0]);
                    sel_next   = 1'b0;
                end
            end
            ufpc_pkg::OP_SETUP: begin
                r_next   = start_reg;
                cur_next = start_reg;
                rd_addr  = start_reg;
            end
            ufpc_pkg::OP_WALK: begin
                r_next  = rd_data;
                rd_addr = rd_data;
            end
            ufpc_pkg::OP_CREAD: begin
                rd_addr = cur_reg;
            end
            ufpc_pkg::OP_CWRITE: begin
                wr_en    = 1'b1;
                wr_addr  = cur_reg;
                wr_data  = r_reg;
                cur_next = rd_data;
                rd_addr  = rd_data;
            end
            ufpc_pkg::OP_FDONE: begin
                if (!sel_reg) begin
                    ra_next    = r_reg;
                    start_next = b_reg;
                    sel_next   = 1'b1;
                end
            end
            ufpc_pkg::OP_LINK: begin
                if (link_fire) begin
                    wr_en         = (kind_reg == ufpc_pkg::KIND_MERGE) && (ra_reg != r_reg);
                    wr_addr       = r_reg;
                    wr_data       = ra_reg;
                    m_valid_next  = 1'b1;
                    m_root_next   = ufpc_pkg::IDX_W'(ra_reg);
                    m_joined_next = (kind_reg == ufpc_pkg::KIND_MERGE) && (ra_reg != r_reg);
                end
            end
            default: begin
            end
        endcase
    end

    // compression never rewrites the root itself
    assert property (@(posedge aclk) disable iff (!aresetn)
        pc_reg == ufpc_pkg::S_CWRITE |-> cur_reg != r_reg)
        else $error("compression step on root");

    // no table write while waiting for a transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        pc_reg == ufpc_pkg::S_WAIT |-> !wr_en)
        else $error("table write while idle");

    // a link only joins two distinct roots
    assert property (@(posedge aclk) disable iff (!aresetn)
        (pc_reg == ufpc_pkg::S_LINK && wr_en) |->
            (kind_reg == ufpc_pkg::KIND_MERGE && ra_reg != r_reg))
        else $error("bad link write");

    // each completed sequence leaves a result in the output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        link_fire |=> m_valid_reg)
        else $error("result lost");

endmodule

// ----- test/union_find_path_compression_tb.sv -----
// testbench for the union-find table: directed and random finds and merges, checked by transaction
module union_find_path_compression_tb;

    localparam int RANDOM_ITEMS = 1300;
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 64;

    typedef struct {
        logic [ufpc_pkg::IDX_W-1:0] root;
        logic                       joined;
    } find_result_t;

    class parent_table;
        logic [ufpc_pkg::IDX_W-1:0] links [ufpc_pkg::NODES];
        find_result_t               pending_results [$];
        int                         failures;

        function new();
            for (int i = 0; i < ufpc_pkg::NODES; i++) begin
                links[i] = ufpc_pkg::IDX_W'(i);
            end
            failures = 0;
        endfunction

        function logic [ufpc_pkg::IDX_W-1:0] clamp_index(input logic [ufpc_pkg::IDX_W-1:0] v);
            if (int'(v) >= ufpc_pkg::NODES) begin
                return ufpc_pkg::IDX_W'(ufpc_pkg::NODES - 1);
            end
            return v;
        endfunction

        // walk to the root, then point every node on the path straight at it
        function logic [ufpc_pkg::IDX_W-1:0] find_compress(
            input logic [ufpc_pkg::IDX_W-1:0] start);
            logic [ufpc_pkg::IDX_W-1:0] top;
            logic [ufpc_pkg::IDX_W-1:0] cur;
            logic [ufpc_pkg::IDX_W-1:0] nxt;
            top = start;
            while (links[top] != top) begin
                top = links[top];
            end
            cur = start;
            while (cur != top) begin
                nxt = links[cur];
                links[cur] = top;
                cur = nxt;
            end
            return top;
        endfunction

        function void accept_item(input logic kind, input logic [ufpc_pkg::IDX_W-1:0] a,
                                  input logic [ufpc_pkg::IDX_W-1:0] b);
            find_result_t res;
            logic [ufpc_pkg::IDX_W-1:0] root_b;
            res.root = find_compress(clamp_index(a));
            res.joined = 1'b0;
            if (kind == ufpc_pkg::KIND_MERGE) begin
                root_b = find_compress(clamp_index(b));
                if (root_b != res.root) begin
                    links[root_b] = res.root;
                    res.joined = 1'b1;
                end
            end
            pending_results.push_back(res);
        endfunction

        function void match_result(input logic [ufpc_pkg::IDX_W-1:0] root, input logic joined);
            find_result_t want;
            if (pending_results.size() == 0) begin
                $error("result with none pending: root %0d joined %0d", root, joined);
                failures++;
                return;
            end
            want = pending_results.pop_front();
            if (root !== want.root) begin
                $error("root mismatch: expected %0d, actual %0d", want.root, root);
                failures++;
            end
            if (joined !== want.joined) begin
                $error("joined mismatch: expected %0d, actual %0d", want.joined, joined);
                failures++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    parent_table book = new();
    int burst_left = 0;
    int idle_cycles = 0;
    int ready_tick = 0;
    int sent = 0;

    union_find_path_compression dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // receiver stall pattern, cycling through four styles in turn
    always @(negedge aclk) begin
        ready_tick <= ready_tick + 1;
        case (ready_tick[8:7])
            2'd0: begin
                m_tready <= 1'b1;
            end
            2'd1: begin
                m_tready <= 1'($urandom_range(0, 1));
            end
            2'd2: begin
                m_tready <= (ready_tick[1:0] == 2'd0);
            end
            default: begin
                m_tready <= ($urandom_range(0, 9) == 0);
            end
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            book.match_result(m_tdata[9:0], m_tdata[10]);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic send_item(input logic kind, input logic [ufpc_pkg::IDX_W-1:0] a,
                             input logic [ufpc_pkg::IDX_W-1:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'b0, b, a};
        do @(posedge aclk); while (!s_tready);
        book.accept_item(kind, a, b);
        sent++;
    endtask

    task automatic send_chain(input logic [ufpc_pkg::IDX_W-1:0] first, input int len,
                              input bit upward);
        logic [ufpc_pkg::IDX_W-1:0] k;
        k = first;
        for (int i = 0; i < len; i++) begin
            if (upward) begin
                send_item(ufpc_pkg::KIND_MERGE, k + 1'b1, k);
            end else begin
                send_item(ufpc_pkg::KIND_MERGE, k, k + 1'b1);
            end
            k = k + 1'b1;
        end
        send_item(ufpc_pkg::KIND_FIND, first, ufpc_pkg::IDX_W'($urandom));
    endtask

    initial begin
        int pick;
        logic [ufpc_pkg::IDX_W-1:0] base;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, same-set merges, find ignoring node_b, a long chain
        send_item(ufpc_pkg::KIND_FIND, 10'd0, 10'd0);
        send_item(ufpc_pkg::KIND_FIND, 10'd1023, 10'd0);
        send_item(ufpc_pkg::KIND_MERGE, 10'd0, 10'd1023);
        send_item(ufpc_pkg::KIND_FIND, 10'd1023, 10'd0);
        send_item(ufpc_pkg::KIND_MERGE, 10'd1023, 10'd0);
        send_item(ufpc_pkg::KIND_MERGE, 10'd5, 10'd5);
        send_item(ufpc_pkg::KIND_FIND, 10'd7, 10'd1023);
        for (int k = 100; k < 114; k++) begin
            send_item(ufpc_pkg::KIND_MERGE, ufpc_pkg::IDX_W'(k + 1), ufpc_pkg::IDX_W'(k));
        end
        send_item(ufpc_pkg::KIND_FIND, 10'd100, 10'd0);
        send_item(ufpc_pkg::KIND_FIND, 10'd100, 10'd0);
        send_item(ufpc_pkg::KIND_MERGE, 10'd682, 10'd341);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            base = ufpc_pkg::IDX_W'($urandom);
            if (pick < 45) begin
                send_item(ufpc_pkg::KIND_MERGE, base + ufpc_pkg::IDX_W'($urandom_range(0, 40)),
                          base + ufpc_pkg::IDX_W'($urandom_range(0, 40)));
            end else if (pick < 65) begin
                send_item(ufpc_pkg::KIND_FIND, base, ufpc_pkg::IDX_W'($urandom));
            end else if (pick < 80) begin
                send_chain(base, $urandom_range(3, 24), 1'b1);
            end else if (pick < 90) begin
                send_chain(base, $urandom_range(3, 12), 1'b0);
            end else begin
                send_item(1'($urandom), ufpc_pkg::IDX_W'($urandom), ufpc_pkg::IDX_W'($urandom));
            end
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (book.pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (book.failures == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
